/* hw/rtl/kbl_pkg.sv */
// Shared types and constants of the K-line block link engine.
// No dependencies; used by every RTL file of the block by scoped names.
`default_nettype none

package kbl_pkg;

   // Event codes carried in req_type
   localparam logic [2:0] REQ_LINE_BYTE   = 3'd0;
   localparam logic [2:0] REQ_TICK        = 3'd1;
   localparam logic [2:0] REQ_START_RX    = 3'd2;
   localparam logic [2:0] REQ_SEND_BYTE   = 3'd3;
   localparam logic [2:0] REQ_NEW_SESSION = 3'd4;

   // Result status codes
   localparam logic [2:0] ST_BUSY    = 3'd0;
   localparam logic [2:0] ST_DONE    = 3'd1;
   localparam logic [2:0] ST_TIMEOUT = 3'd2;
   localparam logic [2:0] ST_TOOLONG = 3'd3;
   localparam logic [2:0] ST_BADCNT  = 3'd4;
   localparam logic [2:0] ST_BADCOMP = 3'd5;
   localparam logic [2:0] ST_IDLE    = 3'd6;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_MAX_BLOCK_SIZE  = 2'd0;
   localparam logic [1:0] CSR_FIRST_BYTE_TMO  = 2'd1;
   localparam logic [1:0] CSR_BYTE_TMO        = 2'd2;
   localparam logic [1:0] CSR_ECHO_TMO        = 2'd3;

   localparam logic [7:0]  MAX_BLOCK_SIZE_RST = 8'd64;
   localparam logic [15:0] FIRST_BYTE_TMO_RST = 16'd2000;
   localparam logic [15:0] BYTE_TMO_RST       = 16'd1000;
   localparam logic [15:0] ECHO_TMO_RST       = 16'd100;

   localparam logic [7:0]  BYTE_INVERT = 8'hFF;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_RX      = 4'b0010,
      PH_TXCOMP  = 4'b0100,
      PH_TXREADY = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] line_data;
      logic [7:0] fixed_length;
      logic       final_byte;
   } req_item_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        rx_valid;
      logic [7:0]  rx_byte;
      logic        rx_last;
      logic [2:0]  status;
      logic [7:0]  block_count_now;
      logic [15:0] data_error_count;
      logic [15:0] timeout_error_count;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  max_block_size;
      logic [15:0] first_byte_timeout_ms;
      logic [15:0] byte_timeout_ms;
      logic [15:0] echo_timeout_ms;
   } cfg_type;

   function automatic logic [15:0] sat_inc16(input logic [15:0] value);
      sat_inc16 = (value == COUNT_MAX) ? value : value + 16'd1;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/kline_block_link_engine_top.sv */
// Top level of the K-line block link engine: input register, link core, result register.
// Depends on kbl_pkg, kbl_csr and kbl_core.
`default_nettype none

// Usage:
//   req_*  : one event per transfer (line byte, millisecond tick, start receive,
//            send byte, new session), payload kbl_pkg::req_item_type.
//   rsp_*  : exactly one result per event, payload kbl_pkg::rsp_item_type, in order.
//   csr_*  : register writes, index 0..3, always ready; write only while idle.
// Path: an accepted event is held in the input register, is processed by the link
//   core as it moves into the result register, and shows on rsp_* from then on;
//   while the result register is stalled, the event waits in the input register.
// Throughput: one event per cycle while rsp_ready is high; every event is worked in
//   a single pass of the core between the input and result registers, and the link
//   state updates at the edge that loads the result register.
// Reset: synchronous, clears both register stages, the link state and the error
//   counts; configuration returns to 64, 2000, 1000 and 100.
// Stall: while rsp_ready is low the result register holds; the input register
//   still takes one more event, then req_ready drops until the result moves on.

module kline_block_link_engine_top (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire kbl_pkg::req_item_type req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output kbl_pkg::rsp_item_type      rsp_data,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [15:0]           csr_wdata
);

   logic                   in_valid_ff, in_valid_in;
   kbl_pkg::req_item_type  in_item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   kbl_pkg::rsp_item_type  rsp_item_ff;
   kbl_pkg::rsp_item_type  core_result;
   kbl_pkg::cfg_type       cfg;
   logic                   advance;
   logic                   take;

   assign csr_ready = 1'b1;

   kbl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // move the held event into the result stage when that stage frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   kbl_core u_core (
      .clock    (clock),
      .reset    (reset),
      .event_go (advance),
      .item     (in_item_ff),
      .cfg      (cfg),
      .result   (core_result)
   );

   always_comb begin
      in_valid_in  = take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

   a_adv_fills_rsp : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed event lost before result stage");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("stalled result overwritten");

   a_take_fills_in : assert property (@(posedge clock) disable iff (reset)
      take |=> in_valid_ff)
      else $error("accepted event not held");

endmodule

`default_nettype wire

/* hw/rtl/kbl_csr.sv */
// Configuration registers of the K-line block link engine.
// Depends on kbl_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module kbl_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata,
   output kbl_pkg::cfg_type       cfg
);

   kbl_pkg::cfg_type cfg_ff;
   kbl_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            kbl_pkg::CSR_MAX_BLOCK_SIZE: cfg_in.max_block_size        = csr_wdata[7:0];
            kbl_pkg::CSR_FIRST_BYTE_TMO: cfg_in.first_byte_timeout_ms = csr_wdata;
            kbl_pkg::CSR_BYTE_TMO:       cfg_in.byte_timeout_ms       = csr_wdata;
            kbl_pkg::CSR_ECHO_TMO:       cfg_in.echo_timeout_ms       = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_block_size        <= kbl_pkg::MAX_BLOCK_SIZE_RST;
         cfg_ff.first_byte_timeout_ms <= kbl_pkg::FIRST_BYTE_TMO_RST;
         cfg_ff.byte_timeout_ms       <= kbl_pkg::BYTE_TMO_RST;
         cfg_ff.echo_timeout_ms       <= kbl_pkg::ECHO_TMO_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/kbl_core.sv */
// Link state and per-event logic of the K-line block link engine.
// Depends on kbl_pkg; one event is processed in each cycle that event_go is high.
`default_nettype none

module kbl_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   event_go,
   input  wire kbl_pkg::req_item_type  item,
   input  wire kbl_pkg::cfg_type       cfg,
   output kbl_pkg::rsp_item_type       result
);

   kbl_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  block_counter_ff, block_counter_in;
   logic [7:0]  received_count_ff, received_count_in;
   logic [7:0]  expected_length_ff, expected_length_in;
   logic        ack_every_byte_ff, ack_every_byte_in;
   logic [15:0] ms_timer_ff, ms_timer_in;
   logic        echo_pending_ff, echo_pending_in;
   logic [7:0]  last_sent_byte_ff, last_sent_byte_in;
   logic [15:0] data_errors_ff, data_errors_in;
   logic [15:0] timeout_errors_ff, timeout_errors_in;

   kbl_pkg::rsp_item_type res;
   logic [2:0]  rest_status;
   logic [8:0]  rx_num;
   logic [8:0]  rx_len;
   logic [7:0]  exp_eff;
   logic        first_var;
   logic        too_long;
   logic [15:0] timer_inc;
   logic [15:0] rx_limit;

   always_comb begin
      phase_in           = phase_ff;
      block_counter_in   = block_counter_ff;
      received_count_in  = received_count_ff;
      expected_length_in = expected_length_ff;
      ack_every_byte_in  = ack_every_byte_ff;
      ms_timer_in        = ms_timer_ff;
      echo_pending_in    = echo_pending_ff;
      last_sent_byte_in  = last_sent_byte_ff;
      data_errors_in     = data_errors_ff;
      timeout_errors_in  = timeout_errors_ff;
      res                = '0;

      rest_status = (phase_ff == kbl_pkg::PH_IDLE) ? kbl_pkg::ST_IDLE : kbl_pkg::ST_BUSY;
      res.status  = rest_status;

      rx_num    = {1'b0, received_count_ff} + 9'd1;
      rx_len    = {1'b0, item.line_data} + 9'd1;
      first_var = ack_every_byte_ff && (rx_num == 9'd1);
      too_long  = first_var && (rx_len > {1'b0, cfg.max_block_size});
      exp_eff   = first_var ? rx_len[7:0] : expected_length_ff;
      timer_inc = (ms_timer_ff == kbl_pkg::COUNT_MAX) ? ms_timer_ff : ms_timer_ff + 16'd1;
      rx_limit  = ((phase_ff == kbl_pkg::PH_RX) && (received_count_ff == 8'd0)) ?
                  cfg.first_byte_timeout_ms : cfg.byte_timeout_ms;

      unique case (item.req_type)
         kbl_pkg::REQ_LINE_BYTE: begin
            if (echo_pending_ff) begin
               // own byte coming back on the half-duplex line: drop it
               echo_pending_in = 1'b0;
               ms_timer_in     = '0;
            end else if (phase_ff == kbl_pkg::PH_RX) begin
               received_count_in = rx_num[7:0];
               ms_timer_in       = '0;
               if (too_long) begin
                  phase_in   = kbl_pkg::PH_IDLE;
                  res.status = kbl_pkg::ST_TOOLONG;
               end else if (ack_every_byte_ff && (rx_num == 9'd2) &&
                            (item.line_data != block_counter_ff)) begin
                  data_errors_in = kbl_pkg::sat_inc16(data_errors_ff);
                  phase_in       = kbl_pkg::PH_IDLE;
                  res.status     = kbl_pkg::ST_BADCNT;
               end else begin
                  expected_length_in = exp_eff;
                  if ((!ack_every_byte_ff && (rx_num == {1'b0, exp_eff})) ||
                      (ack_every_byte_ff && (rx_num < {1'b0, exp_eff}))) begin
                     res.tx_valid    = 1'b1;
                     res.tx_byte     = item.line_data ^ kbl_pkg::BYTE_INVERT;
                     echo_pending_in = 1'b1;
                  end
                  res.rx_valid = 1'b1;
                  res.rx_byte  = item.line_data;
                  if (rx_num >= {1'b0, exp_eff}) begin
                     res.rx_last      = 1'b1;
                     block_counter_in = block_counter_ff + 8'd1;
                     phase_in         = kbl_pkg::PH_IDLE;
                     res.status       = kbl_pkg::ST_DONE;
                  end else begin
                     res.status = kbl_pkg::ST_BUSY;
                  end
               end
            end else if (phase_ff == kbl_pkg::PH_TXCOMP) begin
               if (item.line_data == (last_sent_byte_ff ^ kbl_pkg::BYTE_INVERT)) begin
                  phase_in    = kbl_pkg::PH_TXREADY;
                  ms_timer_in = '0;
                  res.status  = kbl_pkg::ST_BUSY;
               end else begin
                  data_errors_in = kbl_pkg::sat_inc16(data_errors_ff);
                  phase_in       = kbl_pkg::PH_IDLE;
                  res.status     = kbl_pkg::ST_BADCOMP;
               end
            end
         end
         kbl_pkg::REQ_TICK: begin
            ms_timer_in = timer_inc;
            if (echo_pending_ff) begin
               // give up waiting for the echo quietly
               if (timer_inc >= cfg.echo_timeout_ms) begin
                  echo_pending_in = 1'b0;
                  ms_timer_in     = '0;
               end
            end else if ((phase_ff == kbl_pkg::PH_RX) || (phase_ff == kbl_pkg::PH_TXCOMP)) begin
               if (timer_inc >= rx_limit) begin
                  timeout_errors_in = kbl_pkg::sat_inc16(timeout_errors_ff);
                  phase_in          = kbl_pkg::PH_IDLE;
                  res.status        = kbl_pkg::ST_TIMEOUT;
               end
            end
         end
         kbl_pkg::REQ_START_RX: begin
            if (item.fixed_length > cfg.max_block_size) begin
               phase_in   = kbl_pkg::PH_IDLE;
               res.status = kbl_pkg::ST_TOOLONG;
            end else begin
               expected_length_in = item.fixed_length;
               ack_every_byte_in  = (item.fixed_length == 8'd0);
               received_count_in  = '0;
               ms_timer_in        = '0;
               phase_in           = kbl_pkg::PH_RX;
               res.status         = kbl_pkg::ST_BUSY;
            end
         end
         kbl_pkg::REQ_SEND_BYTE: begin
            if ((phase_ff == kbl_pkg::PH_IDLE) || (phase_ff == kbl_pkg::PH_TXREADY)) begin
               last_sent_byte_in = item.line_data;
               res.tx_valid      = 1'b1;
               res.tx_byte       = item.line_data;
               echo_pending_in   = 1'b1;
               ms_timer_in       = '0;
               if (item.final_byte) begin
                  block_counter_in = block_counter_ff + 8'd1;
                  phase_in         = kbl_pkg::PH_IDLE;
                  res.status       = kbl_pkg::ST_DONE;
               end else begin
                  phase_in   = kbl_pkg::PH_TXCOMP;
                  res.status = kbl_pkg::ST_BUSY;
               end
            end else begin
               res.status = kbl_pkg::ST_BUSY;
            end
         end
         kbl_pkg::REQ_NEW_SESSION: begin
            block_counter_in  = '0;
            phase_in          = kbl_pkg::PH_IDLE;
            echo_pending_in   = 1'b0;
            ms_timer_in       = '0;
            received_count_in = '0;
            res.status        = kbl_pkg::ST_IDLE;
         end
         default: res.status = rest_status;
      endcase

      res.block_count_now     = block_counter_in;
      res.data_error_count    = data_errors_in;
      res.timeout_error_count = timeout_errors_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= kbl_pkg::PH_IDLE;
         block_counter_ff   <= '0;
         received_count_ff  <= '0;
         expected_length_ff <= '0;
         ack_every_byte_ff  <= 1'b0;
         ms_timer_ff        <= '0;
         echo_pending_ff    <= 1'b0;
         last_sent_byte_ff  <= '0;
         data_errors_ff     <= '0;
         timeout_errors_ff  <= '0;
      end else if (event_go) begin
         phase_ff           <= phase_in;
         block_counter_ff   <= block_counter_in;
         received_count_ff  <= received_count_in;
         expected_length_ff <= expected_length_in;
         ack_every_byte_ff  <= ack_every_byte_in;
         ms_timer_ff        <= ms_timer_in;
         echo_pending_ff    <= echo_pending_in;
         last_sent_byte_ff  <= last_sent_byte_in;
         data_errors_ff     <= data_errors_in;
         timeout_errors_ff  <= timeout_errors_in;
      end
   end

   assign result = res;

   // a driven byte always leaves an echo to drop
   a_tx_sets_echo : assert property (@(posedge clock) disable iff (reset)
      event_go && res.tx_valid |=> echo_pending_ff)
      else $error("driven byte did not arm echo wait");

   a_last_is_done : assert property (@(posedge clock) disable iff (reset)
      res.rx_last |-> res.rx_valid && (res.status == kbl_pkg::ST_DONE))
      else $error("block end without done status");

   a_data_err_mono : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> data_errors_ff >= $past(data_errors_ff))
      else $error("data error count went down");

   a_tmo_err_mono : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> timeout_errors_ff >= $past(timeout_errors_ff))
      else $error("timeout error count went down");

   a_echo_quiet : assert property (@(posedge clock) disable iff (reset)
      event_go && echo_pending_ff && (item.req_type == kbl_pkg::REQ_LINE_BYTE)
      |-> !res.rx_valid && !res.tx_valid)
      else $error("echo byte was not dropped");

endmodule

`default_nettype wire
